// File: sv/unpremultiply_argb_to_ayuv_pixel_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the unpremultiply ARGB to AYUV pixel core.
// Each check is clocked on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef UNPREMULTIPLY_ARGB_TO_AYUV_PIXEL_CORE_ASSERT_SVH
`define UNPREMULTIPLY_ARGB_TO_AYUV_PIXEL_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pixel core assertion failed");
// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("pixel core forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

// File: sv/unpm_ayuv_pkg.sv
// ----------------------------------------------------------------------------
// unpm_ayuv_pkg
// Shared constants, types and helper functions of the pixel core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package unpm_ayuv_pkg;

  // Pipeline layout: one prepare stage, the divider stages, one multiply
  // stage and one output stage.
  localparam int unsigned DivStages = 4;
  localparam int unsigned DivSteps  = 2;
  localparam int unsigned QuoBits   = DivStages * DivSteps;
  localparam int unsigned MulStage  = DivStages + 1;
  localparam int unsigned OutStage  = DivStages + 2;
  localparam int unsigned NumStages = DivStages + 3;

  typedef logic [7:0]  chan_t;
  typedef logic [15:0] num_t;
  typedef logic [15:0] coef_t;

  // Output format register codes.
  localparam logic FmtArgb = 1'b0;
  localparam logic FmtAyuv = 1'b1;

  // Full-range color conversion coefficients in 16-bit fixed point.
  localparam coef_t CoefYR    = 16'd19595;
  localparam coef_t CoefYG    = 16'd38470;
  localparam coef_t CoefYB    = 16'd7471;
  localparam coef_t CoefCbR   = 16'd11059;
  localparam coef_t CoefCbG   = 16'd21709;
  localparam coef_t CoefChMax = 16'd32768;
  localparam coef_t CoefCrG   = 16'd27439;
  localparam coef_t CoefCrB   = 16'd5329;

  localparam chan_t ChromaOfs = 8'd128;
  localparam chan_t ChanMax   = 8'd255;

  // Product of a coefficient and a channel, shifted right by 16.
  function automatic chan_t coef_mul(input coef_t coef, input chan_t v);
    logic [23:0] prod;
    prod = {8'h00, coef} * {16'h0000, v};
    return prod[23:16];
  endfunction

  // Clamp a signed sum into the 0..255 range.
  function automatic chan_t clamp8(input logic signed [10:0] v);
    chan_t res;
    if (v < 11'sd0) begin
      res = 8'h00;
    end else if (v > 11'sd255) begin
      res = ChanMax;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: sv/unpm_ayuv_div.sv
// ----------------------------------------------------------------------------
// unpm_ayuv_div
// One color lane of the unpremultiply step: a prepare stage followed by a
// pipelined restoring divider that yields the saturated 8-bit quotient, or zero for zero alpha.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unpm_ayuv_div (
  input  wire logic                                  clk_i,
  input  wire logic [unpm_ayuv_pkg::DivStages:0]     en_i,
  input  wire unpm_ayuv_pkg::chan_t                  chan_i,
  input  wire unpm_ayuv_pkg::chan_t                  alpha_i,
  output unpm_ayuv_pkg::chan_t                       quo_o
);

  localparam int unsigned D = unpm_ayuv_pkg::DivStages;

  unpm_ayuv_pkg::num_t  num_d;
  unpm_ayuv_pkg::num_t  rem_q   [D];
  unpm_ayuv_pkg::chan_t alpha_q [D];
  unpm_ayuv_pkg::chan_t quo_q   [D+1];
  logic [D:0]           sat_q;
  logic [D:0]           zero_q;

  // Numerator c*255 + a/2, formed as c*256 - c + a/2.
  assign num_d = {chan_i, 8'h00} - {8'h00, chan_i} + {9'h000, alpha_i[7:1]};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]   <= num_d;
      alpha_q[0] <= alpha_i;
      quo_q[0]   <= '0;
      // The quotient would not fit in 8 bits: saturate.
      sat_q[0]   <= (num_d >= {alpha_i, 8'h00});
      zero_q[0]  <= (alpha_i == 8'h00);
    end
  end

  for (genvar s = 1; s <= D; s++) begin : g_div
    localparam int unsigned TopBit = unpm_ayuv_pkg::QuoBits - 1 - (s - 1) * unpm_ayuv_pkg::DivSteps;

    unpm_ayuv_pkg::num_t  rem_d;
    unpm_ayuv_pkg::chan_t quo_d;

    always_comb begin : p_step
      unpm_ayuv_pkg::num_t dsr;
      rem_d = rem_q[s-1];
      quo_d = quo_q[s-1];
      dsr   = '0;
      for (int k = 0; k < int'(unpm_ayuv_pkg::DivSteps); k++) begin
        dsr = {8'h00, alpha_q[s-1]} << (int'(TopBit) - k);
        if (rem_d >= dsr) begin
          rem_d = rem_d - dsr;
          quo_d = {quo_d[6:0], 1'b1};
        end else begin
          quo_d = {quo_d[6:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        quo_q[s]  <= quo_d;
        sat_q[s]  <= sat_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end

    // The last stage needs neither remainder nor divisor any more.
    if (s < D) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s]   <= rem_d;
          alpha_q[s] <= alpha_q[s-1];
        end
      end
    end
  end

  assign quo_o = zero_q[D] ? 8'h00 :
                 sat_q[D]  ? unpm_ayuv_pkg::ChanMax : quo_q[D];

endmodule

`default_nettype wire

// File: sv/unpm_ayuv_csc.sv
// ----------------------------------------------------------------------------
// unpm_ayuv_csc
// Color conversion: a multiply stage for the nine coefficient products and
// an output stage that sums, offsets, clamps and selects the format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module unpm_ayuv_csc (
  input  wire logic                  clk_i,
  input  wire logic [1:0]            en_i,
  input  wire logic                  fmt_i,
  input  wire unpm_ayuv_pkg::chan_t  red_i,
  input  wire unpm_ayuv_pkg::chan_t  green_i,
  input  wire unpm_ayuv_pkg::chan_t  blue_i,
  output unpm_ayuv_pkg::chan_t       chan1_o,
  output unpm_ayuv_pkg::chan_t       chan2_o,
  output unpm_ayuv_pkg::chan_t       chan3_o
);

  unpm_ayuv_pkg::chan_t red_q, green_q, blue_q;
  unpm_ayuv_pkg::chan_t p_yr_q, p_yg_q, p_yb_q;
  unpm_ayuv_pkg::chan_t p_cbr_q, p_cbg_q, p_cbb_q;
  unpm_ayuv_pkg::chan_t p_crr_q, p_crg_q, p_crb_q;
  logic signed [10:0]   y_s, cb_s, cr_s;
  unpm_ayuv_pkg::chan_t chan1_q, chan2_q, chan3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      p_yr_q  <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefYR, red_i);
      p_yg_q  <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefYG, green_i);
      p_yb_q  <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefYB, blue_i);
      p_cbr_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefCbR, red_i);
      p_cbg_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefCbG, green_i);
      p_cbb_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefChMax, blue_i);
      p_crr_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefChMax, red_i);
      p_crg_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefCrG, green_i);
      p_crb_q <= unpm_ayuv_pkg::coef_mul(unpm_ayuv_pkg::CoefCrB, blue_i);
    end
  end

  // Products are already floored; negation comes after the shift.
  assign y_s  = $signed({3'b000, p_yr_q}) + $signed({3'b000, p_yg_q})
              + $signed({3'b000, p_yb_q});
  assign cb_s = $signed({3'b000, unpm_ayuv_pkg::ChromaOfs}) + $signed({3'b000, p_cbb_q})
              - $signed({3'b000, p_cbr_q}) - $signed({3'b000, p_cbg_q});
  assign cr_s = $signed({3'b000, unpm_ayuv_pkg::ChromaOfs}) + $signed({3'b000, p_crr_q})
              - $signed({3'b000, p_crg_q}) - $signed({3'b000, p_crb_q});

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      if (fmt_i == unpm_ayuv_pkg::FmtArgb) begin
        chan1_q <= red_q;
        chan2_q <= green_q;
        chan3_q <= blue_q;
      end else begin
        chan1_q <= unpm_ayuv_pkg::clamp8(y_s);
        chan2_q <= unpm_ayuv_pkg::clamp8(cb_s);
        chan3_q <= unpm_ayuv_pkg::clamp8(cr_s);
      end
    end
  end

  assign chan1_o = chan1_q;
  assign chan2_o = chan2_q;
  assign chan3_o = chan3_q;

endmodule

`default_nettype wire

// File: sv/unpremultiply_argb_to_ayuv_pixel_core.sv
// ----------------------------------------------------------------------------
// Unpremultiply ARGB to AYUV pixel core.
// Throughput: one pixel per cycle while the output is not stalled; the seven
// register stages (prepare, four divider stages of two quotient bits each,
// multiply, output) each take a pixel, and a result is on the outputs while
// it sits in the output stage.
// Reset clears every stage valid bit and sets the output format to AYUV.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "unpremultiply_argb_to_ayuv_pixel_core_assert.svh"

// Each premultiplied color channel is recovered as
// min((c*255 + a/2) / a, 255), or zero for a fully transparent pixel, and is
// then either passed on as ARGB or converted to full-range YUV.
module unpremultiply_argb_to_ayuv_pixel_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port for the output format register.
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  // Input pixel channel.
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire unpm_ayuv_pkg::chan_t  alpha_in_i,
  input  wire unpm_ayuv_pkg::chan_t  red_in_i,
  input  wire unpm_ayuv_pkg::chan_t  green_in_i,
  input  wire unpm_ayuv_pkg::chan_t  blue_in_i,
  // Output pixel channel.
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output unpm_ayuv_pkg::chan_t       alpha_out_o,
  output unpm_ayuv_pkg::chan_t       chan1_out_o,
  output unpm_ayuv_pkg::chan_t       chan2_out_o,
  output unpm_ayuv_pkg::chan_t       chan3_out_o
);

  localparam int unsigned NS = unpm_ayuv_pkg::NumStages;
  localparam int unsigned DS = unpm_ayuv_pkg::DivStages;
  localparam int unsigned MS = unpm_ayuv_pkg::MulStage;
  localparam int unsigned OS = unpm_ayuv_pkg::OutStage;

  logic                 fmt_q;
  logic [NS-1:0]        valid_q, valid_d;
  logic [NS-1:0]        pipe_en;
  unpm_ayuv_pkg::chan_t alpha_q [NS];
  unpm_ayuv_pkg::chan_t red_quo, green_quo, blue_quo;
  logic                 clear_ayuv_adv;
  logic                 neutral_out;

  // The user must change the format register only while the pipeline is empty;
  // the core does not enforce this, and the output stage samples it directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= unpm_ayuv_pkg::FmtAyuv;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  // A stage may load when it is empty or when the stage after it loads as
  // well. Bubbles are squeezed out, so a stalled output only holds the
  // input off once every stage carries a pixel.
  always_comb begin
    pipe_en[OS] = !valid_q[OS] || !out_stall_i;
    for (int k = int'(OS) - 1; k >= 0; k--) begin
      pipe_en[k] = !valid_q[k] || pipe_en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (pipe_en[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k < int'(NS); k++) begin
      if (pipe_en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Alpha travels alongside the color lanes unchanged.
  always_ff @(posedge clk_i) begin
    if (pipe_en[0]) begin
      alpha_q[0] <= alpha_in_i;
    end
    for (int k = 1; k < int'(NS); k++) begin
      if (pipe_en[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  // One divider lane per color channel, each holding its own alpha copy.
  unpm_ayuv_div u_div_red (
    .clk_i   (clk_i),
    .en_i    (pipe_en[DS:0]),
    .chan_i  (red_in_i),
    .alpha_i (alpha_in_i),
    .quo_o   (red_quo)
  );

  unpm_ayuv_div u_div_green (
    .clk_i   (clk_i),
    .en_i    (pipe_en[DS:0]),
    .chan_i  (green_in_i),
    .alpha_i (alpha_in_i),
    .quo_o   (green_quo)
  );

  unpm_ayuv_div u_div_blue (
    .clk_i   (clk_i),
    .en_i    (pipe_en[DS:0]),
    .chan_i  (blue_in_i),
    .alpha_i (alpha_in_i),
    .quo_o   (blue_quo)
  );

  // Multiply and output stages.
  unpm_ayuv_csc u_csc (
    .clk_i   (clk_i),
    .en_i    (pipe_en[OS:MS]),
    .fmt_i   (fmt_q),
    .red_i   (red_quo),
    .green_i (green_quo),
    .blue_i  (blue_quo),
    .chan1_o (chan1_out_o),
    .chan2_o (chan2_out_o),
    .chan3_o (chan3_out_o)
  );

  assign in_stall_o  = !pipe_en[0];
  assign out_valid_o = valid_q[OS];
  assign alpha_out_o = alpha_q[OS];

  // A transparent pixel in the multiply stage moves on to the output stage
  // while the core produces AYUV.
  assign clear_ayuv_adv = valid_q[MS] && pipe_en[OS] && (alpha_q[MS] == 8'h00)
                          && (fmt_q == unpm_ayuv_pkg::FmtAyuv);
  assign neutral_out    = (chan1_out_o == 8'h00)
                          && (chan2_out_o == unpm_ayuv_pkg::ChromaOfs)
                          && (chan3_out_o == unpm_ayuv_pkg::ChromaOfs);

  // The input is only held off when the whole pipeline is full and blocked.
  `ASSERT_CLK(a_stall_only_when_full, in_stall_o |-> ((&valid_q) && out_stall_i))
  // With the output side free, a transfer can enter in every cycle.
  `ASSERT_NEVER(a_stall_while_drained, !out_stall_i && in_stall_o)
  // A fully transparent pixel in AYUV mode turns into black with neutral chroma.
  `ASSERT_CLK(a_clear_pixel_ayuv, clear_ayuv_adv |=> neutral_out)

endmodule

`default_nettype wire

// File: test/unpremultiply_argb_to_ayuv_pixel_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the unpremultiply ARGB to AYUV pixel core
// Sends premultiplied ARGB pixels through the core under both output formats.
// A scoreboard predicts each expected pixel when its input transfer is seen and
// checks every output transfer against it. Both sides insert random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unpremultiply_argb_to_ayuv_pixel_core_tb;

  import unpm_ayuv_pkg::*;

  // The longest stretch without any transfer that a correct run can show is
  // the receiver hold-off plus the passage through the pipeline, so this
  // leaves a wide margin.
  localparam int unsigned IdleLimit   = 2000;
  // Length of the receiver hold-off used to fill the pipeline.
  localparam int unsigned HoldCycles  = 150;
  // Random pixels in each of the eight random phases.
  localparam int unsigned PhaseLength = 200;
  // Extra cycles after the last result, more than the pipeline depth.
  localparam int unsigned TailCycles  = 16;
  // Only the first mismatches are printed in full.
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
  } argb_pixel_t;

  typedef struct packed {
    chan_t alpha;
    chan_t chan1;
    chan_t chan2;
    chan_t chan3;
  } out_pixel_t;

  // Holds the output format as the core sees it and the queue of pixels that
  // are still on their way through the pipeline.
  class pixel_scoreboard;
    logic       out_format = FmtAyuv;
    out_pixel_t expected_pixels[$];
    int unsigned errors  = 0;
    int unsigned checked = 0;

    // Recovers a straight color channel from a premultiplied one, with
    // rounding, saturating at full scale and giving zero for zero alpha.
    function chan_t recover(chan_t c, chan_t a);
      int q;
      if (a == 8'd0) begin
        return 8'd0;
      end
      q = (int'(c) * 255 + int'(a) / 2) / int'(a);
      return (q > 255) ? ChanMax : chan_t'(q);
    endfunction

    // Each coefficient product is floored on its own before the sum.
    function int scaled(coef_t coef, chan_t v);
      return (int'(coef) * int'(v)) >> 16;
    endfunction

    function chan_t sat8(int v);
      if (v < 0) begin
        return 8'd0;
      end
      return (v > 255) ? ChanMax : chan_t'(v);
    endfunction

    function void note_pixel(argb_pixel_t px);
      chan_t      r;
      chan_t      g;
      chan_t      b;
      out_pixel_t res;
      r = recover(px.red, px.alpha);
      g = recover(px.green, px.alpha);
      b = recover(px.blue, px.alpha);
      res.alpha = px.alpha;
      if (out_format == FmtArgb) begin
        res.chan1 = r;
        res.chan2 = g;
        res.chan3 = b;
      end else begin
        res.chan1 = sat8(scaled(CoefYR, r) + scaled(CoefYG, g) + scaled(CoefYB, b));
        res.chan2 = sat8(-scaled(CoefCbR, r) - scaled(CoefCbG, g) + scaled(CoefChMax, b)
                         + int'(ChromaOfs));
        res.chan3 = sat8(scaled(CoefChMax, r) - scaled(CoefCrG, g) - scaled(CoefCrB, b)
                         + int'(ChromaOfs));
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_pixel(out_pixel_t got_px);
      out_pixel_t want_px;
      chan_t      want_f[4];
      chan_t      got_f[4];
      string      field_names[4] = '{"alpha", "chan1", "chan2", "chan3"};
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= ReportLimit) begin
          $display("%0t: unexpected output pixel %08h", $realtime, got_px);
        end
        return;
      end
      want_px = expected_pixels.pop_front();
      want_f  = '{want_px.alpha, want_px.chan1, want_px.chan2, want_px.chan3};
      got_f   = '{got_px.alpha, got_px.chan1, got_px.chan2, got_px.chan3};
      for (int i = 0; i < 4; i++) begin
        if (want_f[i] !== got_f[i]) begin
          errors++;
          if (errors <= ReportLimit) begin
            $display("%0t: output pixel %0d field %s expected %02h got %02h",
                     $realtime, checked, field_names[i], want_f[i], got_f[i]);
          end
        end
      end
      checked++;
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  cfg_we    = 1'b0;
  logic  cfg_wdata = 1'b0;
  logic  in_valid  = 1'b0;
  logic  in_stall;
  chan_t alpha_in  = 8'd0;
  chan_t red_in    = 8'd0;
  chan_t green_in  = 8'd0;
  chan_t blue_in   = 8'd0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  chan_t alpha_out;
  chan_t chan1_out;
  chan_t chan2_out;
  chan_t chan3_out;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_stall_pct  = 0;
  // Each increment asks the receiver for one long hold-off.
  int unsigned hold_requests = 0;

  pixel_scoreboard sb = new();

  unpremultiply_argb_to_ayuv_pixel_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .alpha_in_i  (alpha_in),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .alpha_out_o (alpha_out),
    .chan1_out_o (chan1_out),
    .chan2_out_o (chan2_out),
    .chan3_out_o (chan3_out)
  );

  initial begin
    forever begin
      #5ns clk = ~clk;
    end
  end

  // Offers one pixel, possibly after some idle cycles, and returns at the edge
  // where the transfer happens. The valid stays high on return so that a
  // following pixel can go back to back.
  task automatic send_pixel(argb_pixel_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    alpha_in <= px.alpha;
    red_in   <= px.red;
    green_in <= px.green;
    blue_in  <= px.blue;
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_pixel(px);
  endtask

  // Drops the valid and waits until every pixel in flight has come out.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Only called with the pipeline empty, so the new format never applies to
  // a pixel that is still in flight.
  task automatic write_format(logic fmt);
    cfg_we    <= 1'b1;
    cfg_wdata <= fmt;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.out_format = fmt;
  endtask

  // Directed corners: transparent pixels with any channel values, opaque
  // extremes, channels above alpha that saturate, and the smallest alphas
  // where rounding matters most.
  task automatic send_corner_pixels();
    argb_pixel_t corners[12] = '{
      '{8'd0,   8'd0,   8'd0,   8'd0},
      '{8'd0,   8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd0,   8'd0,   8'd0},
      '{8'd255, 8'd255, 8'd255, 8'd255},
      '{8'd255, 8'd255, 8'd0,   8'd0},
      '{8'd255, 8'd0,   8'd255, 8'd0},
      '{8'd255, 8'd0,   8'd0,   8'd255},
      '{8'd255, 8'd255, 8'd255, 8'd0},
      '{8'd1,   8'd1,   8'd0,   8'd255},
      '{8'd2,   8'd1,   8'd2,   8'd1},
      '{8'd128, 8'd64,  8'd128, 8'd200},
      '{8'd200, 8'd100, 8'd170, 8'd85}
    };
    foreach (corners[i]) begin
      send_pixel(corners[i]);
    end
    drain_pipeline();
  endtask

  // Receiver: checks each output transfer and then decides the stall for the
  // next cycle. A pending hold-off request takes precedence over the random
  // stall and is counted out here in cycles.
  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_pixel('{alpha_out, chan1_out, chan2_out, chan3_out});
      end
      if (hold_left == 0 && holds_served != hold_requests) begin
        hold_left = HoldCycles;
        holds_served++;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Watchdog: any cycle with a transfer on either side restarts the count.
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("unpremultiply_argb_to_ayuv_pixel_core_tb: errors");
    $finish;
  end

  // Main sequence.
  initial begin
    int unsigned idle_modes[4][2];
    logic        formats[2];
    argb_pixel_t px;
    int unsigned sel;

    idle_modes = '{'{0, 0}, '{47, 0}, '{0, 47}, '{26, 26}};
    formats    = '{FmtArgb, FmtAyuv};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The corners run first with the reset format, which is AYUV, and then
    // again in ARGB.
    send_corner_pixels();
    write_format(FmtArgb);
    send_corner_pixels();

    foreach (idle_modes[m]) begin
      foreach (formats[f]) begin
        tx_idle_pct  = idle_modes[m][0];
        rx_stall_pct <= idle_modes[m][1];
        write_format(formats[f]);
        // With no idling on either side, hold the receiver off so the
        // pipeline fills up and backs up into the input.
        if (m == 0) begin
          hold_requests <= hold_requests + 1;
        end
        for (int n = 0; n < PhaseLength; n++) begin
          // Mostly well-formed premultiplied pixels, with channels no larger
          // than alpha; the rest are arbitrary channels, which may saturate.
          sel = $urandom_range(99);
          if (sel < 12) begin
            px.alpha = 8'd0;
          end else if (sel < 22) begin
            px.alpha = 8'd255;
          end else begin
            px.alpha = chan_t'($urandom_range(255));
          end
          if ($urandom_range(99) < 80) begin
            px.red   = chan_t'($urandom_range(px.alpha));
            px.green = chan_t'($urandom_range(px.alpha));
            px.blue  = chan_t'($urandom_range(px.alpha));
          end else begin
            px.red   = chan_t'($urandom_range(255));
            px.green = chan_t'($urandom_range(255));
            px.blue  = chan_t'($urandom_range(255));
          end
          send_pixel(px);
          // Once in the first phase, the sender stops until all is out.
          if (m == 0 && f == 0 && n == PhaseLength / 2) begin
            drain_pipeline();
          end
        end
        drain_pipeline();
      end
    end

    rx_stall_pct <= 0;
    repeat (TailCycles) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("unpremultiply_argb_to_ayuv_pixel_core_tb: clean");
    end else begin
      $display("unpremultiply_argb_to_ayuv_pixel_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/unpm_ayuv_pkg.sv
sv/unpm_ayuv_div.sv
sv/unpm_ayuv_csc.sv
sv/unpremultiply_argb_to_ayuv_pixel_core.sv
test/unpremultiply_argb_to_ayuv_pixel_core_tb.sv
